// ----- rtl/trate_pkg.sv -----
// trate_pkg: field widths, register indexes and fixed constants of the
// transfer rate and eta estimator; no dependencies

package trate_pkg;

	// fixed widths of the transfer fields
	localparam int FIELD_BITS     = 48;
	localparam int INTERVAL_BITS  = 16;
	localparam int RATIO_BITS     = 17;
	localparam int ETA_BITS       = 32;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 48;

	typedef logic [FIELD_BITS-1:0]     field_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

	// configuration register indexes
	localparam cfg_index_t REG_RESUME_OFFSET   = 8'd0;
	localparam cfg_index_t REG_SAMPLE_INTERVAL = 8'd1;

	localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd500;

	// progress ratio: 16 quotient bits, full scale means complete
	localparam int                     RATIO_STEPS = 16;
	localparam logic [RATIO_BITS-1:0]  RATIO_FULL  = 17'h1_0000;

	// eta: 31 quotient bits, all ones of the signed word means unknown
	localparam int                   ETA_STEPS   = 31;
	localparam logic [ETA_BITS-1:0]  ETA_UNKNOWN = 32'hFFFF_FFFF;
	localparam logic [ETA_BITS-1:0]  ETA_MAX     = 32'h7FFF_FFFF;

	// ema divisor, weights are 7 and 3 tenths
	localparam int SMOOTH_DIVISOR = 10;

endpackage

// ----- rtl/trate_if.sv -----
// trate_if: report, result and configuration channels of the estimator
// depends on trate_pkg

interface trate_report_if import trate_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t bytes_so_far;
	field_t bytes_expected;
	field_t time_ms;
	logic   clear_history;

	modport source (output valid, bytes_so_far, bytes_expected, time_ms, clear_history,
		input ready);
	modport sink (input valid, bytes_so_far, bytes_expected, time_ms, clear_history,
		output ready);
endinterface

interface trate_result_if import trate_pkg::*; #(
	parameter int COUNT_BITS     = 48,
	parameter int RATE_FRAC_BITS = 8
) ();
	logic                                   valid;
	logic                                   ready;
	logic [COUNT_BITS-1:0]                  received_total;
	logic [COUNT_BITS-1:0]                  expected_total;
	logic [RATIO_BITS-1:0]                  progress_ratio;
	logic [COUNT_BITS+RATE_FRAC_BITS-1:0]   rate_fixed;
	logic signed [ETA_BITS-1:0]             eta_seconds;
	logic                                   rate_updated;

	modport source (output valid, received_total, expected_total, progress_ratio,
		rate_fixed, eta_seconds, rate_updated, input ready);
	modport sink (input valid, received_total, expected_total, progress_ratio,
		rate_fixed, eta_seconds, rate_updated, output ready);
endinterface

interface trate_cfg_if import trate_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/transfer_rate_eta_estimator.sv -----
// transfer_rate_eta_estimator: progress, smoothed rate and eta from progress reports
// depends on trate_pkg and the channel interfaces in trate_if.sv
//
//  channel  | role | carries
//  ---------+------+---------------------------------------------------------
//  report   | sink | bytes_so_far, bytes_expected, time_ms, clear_history
//  result   | src  | received_total, expected_total, progress_ratio, rate_fixed,
//           |      | eta_seconds, rate_updated
//  cfg      | sink | index, data (0 resume_offset, 1 sample_interval_ms)
//
// one report at a time; all divisions go through one shared radix-2 divider
// that takes one quotient bit per cycle
// a report without a rate update runs at most the ratio division (16 steps);
// a report with a rate update may also run the rate, ema and eta divisions,
// at the default widths ratio 16, rate 56, ema 56 and eta 31 steps
// reset clears config to defaults and drops the history; no clearing pass
// a finished result waits in the output register; the next report is taken
// while it waits, and the block stalls only in its last state until it leaves

module transfer_rate_eta_estimator import trate_pkg::*; #(
	parameter int COUNT_BITS     = 48,
	parameter int RATE_FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	trate_report_if.sink     report,
	trate_result_if.source   result,
	trate_cfg_if.sink        cfg
);

	// derived widths
	localparam int CW   = COUNT_BITS;
	localparam int RW   = COUNT_BITS + RATE_FRAC_BITS;
	localparam int QW   = RW;
	localparam int DVW  = (RW > FIELD_BITS) ? RW : FIELD_BITS;
	localparam int AW   = COUNT_BITS + ((RATE_FRAC_BITS + 4 > 10) ? RATE_FRAC_BITS + 4 : 10);
	localparam int SW   = ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;
	localparam int CNTW = $clog2(QW + 1);

	localparam logic [CW-1:0] CMAX = {CW{1'b1}};
	localparam logic [RW-1:0] RMAX = {RW{1'b1}};

	// sequencer codes
	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_SUM       = 5'd1;
	localparam logic [4:0] S_RATIO     = 5'd2;
	localparam logic [4:0] S_RATIO_RUN = 5'd3;
	localparam logic [4:0] S_BASE      = 5'd4;
	localparam logic [4:0] S_CHECK     = 5'd5;
	localparam logic [4:0] S_MUL1      = 5'd6;
	localparam logic [4:0] S_MUL2      = 5'd7;
	localparam logic [4:0] S_INST      = 5'd8;
	localparam logic [4:0] S_INST_RUN  = 5'd9;
	localparam logic [4:0] S_SMA       = 5'd10;
	localparam logic [4:0] S_SMB       = 5'd11;
	localparam logic [4:0] S_SMC       = 5'd12;
	localparam logic [4:0] S_SM_LD     = 5'd13;
	localparam logic [4:0] S_SM_RUN    = 5'd14;
	localparam logic [4:0] S_ETA_PREP  = 5'd15;
	localparam logic [4:0] S_ETA_LD    = 5'd16;
	localparam logic [4:0] S_ETA_RUN   = 5'd17;
	localparam logic [4:0] S_OUT       = 5'd18;

	// control and history state
	logic [4:0]               state_q;
	logic                     out_valid_q;
	logic [FIELD_BITS-1:0]    offset_q;
	logic [INTERVAL_BITS-1:0] interval_q;
	logic                     base_valid_q;
	logic [RW-1:0]            smooth_q;
	logic [ETA_BITS-1:0]      eta_q;
	logic                     upd_q;

	// datapath registers
	field_t                bytes_q;
	field_t                bexp_q;
	field_t                now_q;
	logic [CW-1:0]         recv_q;
	logic [CW-1:0]         expt_q;
	logic [RATIO_BITS-1:0] ratio_q;
	logic [FIELD_BITS-1:0] base_time_q;
	logic [CW-1:0]         base_bytes_q;
	logic [FIELD_BITS-1:0] elapsed_q;
	logic [CW-1:0]         delta_q;
	logic [AW-1:0]         acc_q;
	logic [RW-1:0]         inst_q;

	// shared divider
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dvs_q;
	logic [QW-1:0]   feed_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;

	// result register
	logic [CW-1:0]         res_recv_q;
	logic [CW-1:0]         res_expt_q;
	logic [RATIO_BITS-1:0] res_ratio_q;
	logic [RW-1:0]         res_rate_q;
	logic [ETA_BITS-1:0]   res_eta_q;
	logic                  res_upd_q;

	logic report_fire;
	logic result_fire;
	logic cfg_fire;
	logic out_free;

	assign report.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign report_fire  = report.valid & report.ready;
	assign result_fire  = out_valid_q & result.ready;
	assign cfg_fire     = cfg.valid & cfg.ready;
	assign out_free     = !out_valid_q || result.ready;

	// saturating sums of offset and counts
	logic [SW-1:0] off_cl;
	logic [SW-1:0] rcv_cl;
	logic [SW-1:0] exp_cl;
	logic [SW-1:0] rcv_sum;
	logic [SW-1:0] exp_sum;
	logic [CW-1:0] recv_sat;
	logic [CW-1:0] expt_sat;

	always_comb begin
		off_cl   = (SW'(offset_q) > SW'(CMAX)) ? SW'(CMAX) : SW'(offset_q);
		rcv_cl   = (SW'(bytes_q) > SW'(CMAX)) ? SW'(CMAX) : SW'(bytes_q);
		exp_cl   = (SW'(bexp_q) > SW'(CMAX)) ? SW'(CMAX) : SW'(bexp_q);
		rcv_sum  = off_cl + rcv_cl;
		exp_sum  = off_cl + exp_cl;
		recv_sat = (rcv_sum > SW'(CMAX)) ? CMAX : rcv_sum[CW-1:0];
		if (bexp_q == '0) begin
			expt_sat = '0;
		end else begin
			expt_sat = (exp_sum > SW'(CMAX)) ? CMAX : exp_sum[CW-1:0];
		end
	end

	// one restoring divide step per cycle
	logic          div_run;
	logic          div_last;
	logic [DVW:0]  rem2;
	logic          div_ge;
	logic [DVW-1:0] rem_nxt;
	logic [QW-1:0] quo_nxt;

	always_comb begin
		div_run  = (state_q == S_RATIO_RUN) || (state_q == S_INST_RUN) ||
			(state_q == S_SM_RUN) || (state_q == S_ETA_RUN);
		div_last = (cnt_q == CNTW'(1));
		rem2     = {rem_q, feed_q[QW-1]};
		div_ge   = (rem2 >= {1'b0, dvs_q});
		rem_nxt  = div_ge ? DVW'(rem2 - {1'b0, dvs_q}) : rem2[DVW-1:0];
		quo_nxt  = {quo_q[QW-2:0], div_ge};
	end

	// setup values of the divisions
	logic [DVW-1:0] interval_ext;
	logic [DVW-1:0] inst_rem0;
	logic [RW-1:0]  eta_num;
	logic [DVW-1:0] eta_rem0;
	logic           eta_wanted;

	always_comb begin
		interval_ext = (interval_q == '0) ? DVW'(1) : DVW'(interval_q);
		inst_rem0    = DVW'(acc_q >> CW);
		eta_num      = RW'(acc_q[CW-1:0]) << RATE_FRAC_BITS;
		eta_rem0     = DVW'(eta_num >> ETA_STEPS);
		eta_wanted   = (smooth_q > (RW'(1) << RATE_FRAC_BITS)) && (expt_q > recv_q);
	end

	// sequencer, config and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			offset_q     <= '0;
			interval_q   <= INTERVAL_RESET;
			base_valid_q <= 1'b0;
			smooth_q     <= '0;
			eta_q        <= ETA_UNKNOWN;
			upd_q        <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg.index == REG_RESUME_OFFSET) begin
					offset_q <= cfg.data[FIELD_BITS-1:0];
				end else if (cfg.index == REG_SAMPLE_INTERVAL) begin
					interval_q <= cfg.data[INTERVAL_BITS-1:0];
				end
			end
			// result flag: loaded in the last state, dropped by a transfer
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (report_fire) begin
						if (report.clear_history) begin
							base_valid_q <= 1'b0;
							smooth_q     <= '0;
							eta_q        <= ETA_UNKNOWN;
						end
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					upd_q   <= 1'b0;
					state_q <= S_RATIO;
				end
				S_RATIO: begin
					if (expt_q == '0 || recv_q >= expt_q) begin
						state_q <= S_BASE;
					end else begin
						state_q <= S_RATIO_RUN;
					end
				end
				S_RATIO_RUN: begin
					if (div_last) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					if (!base_valid_q) begin
						base_valid_q <= 1'b1;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (DVW'(elapsed_q) >= interval_ext) begin
						upd_q   <= 1'b1;
						state_q <= S_MUL1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MUL1:     state_q <= S_MUL2;
				S_MUL2:     state_q <= S_INST;
				S_INST: begin
					if (inst_rem0 >= DVW'(elapsed_q)) begin
						state_q <= S_SMA;
					end else begin
						state_q <= S_INST_RUN;
					end
				end
				S_INST_RUN: begin
					if (div_last) begin
						state_q <= S_SMA;
					end
				end
				S_SMA: begin
					if (smooth_q == '0) begin
						smooth_q <= inst_q;
						state_q  <= S_ETA_PREP;
					end else begin
						state_q <= S_SMB;
					end
				end
				S_SMB:      state_q <= S_SMC;
				S_SMC:      state_q <= S_SM_LD;
				S_SM_LD:    state_q <= S_SM_RUN;
				S_SM_RUN: begin
					if (div_last) begin
						smooth_q <= quo_nxt;
						state_q  <= S_ETA_PREP;
					end
				end
				S_ETA_PREP: begin
					if (eta_wanted) begin
						state_q <= S_ETA_LD;
					end else begin
						eta_q   <= ETA_UNKNOWN;
						state_q <= S_OUT;
					end
				end
				S_ETA_LD: begin
					if (eta_rem0 >= DVW'(smooth_q)) begin
						eta_q   <= ETA_MAX;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ETA_RUN;
					end
				end
				S_ETA_RUN: begin
					if (div_last) begin
						eta_q   <= {1'b0, quo_nxt[ETA_STEPS-1:0]};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, divider and result payload
	always_ff @(posedge clk) begin
		if (report_fire) begin
			bytes_q <= report.bytes_so_far;
			bexp_q  <= report.bytes_expected;
			now_q   <= report.time_ms;
		end
		if (div_run) begin
			rem_q  <= rem_nxt;
			feed_q <= feed_q << 1;
			quo_q  <= quo_nxt;
			cnt_q  <= cnt_q - CNTW'(1);
		end
		case (state_q)
			S_SUM: begin
				recv_q  <= recv_sat;
				expt_q  <= expt_sat;
				ratio_q <= '0;
			end
			S_RATIO: begin
				if (expt_q != '0 && recv_q >= expt_q) begin
					ratio_q <= RATIO_FULL;
				end
				rem_q  <= DVW'(recv_q);
				dvs_q  <= DVW'(expt_q);
				feed_q <= '0;
				quo_q  <= '0;
				cnt_q  <= CNTW'(RATIO_STEPS);
			end
			S_RATIO_RUN: begin
				if (div_last) begin
					ratio_q <= RATIO_BITS'(quo_nxt[RATIO_STEPS-1:0]);
				end
			end
			S_BASE: begin
				if (!base_valid_q) begin
					base_time_q  <= now_q;
					base_bytes_q <= recv_q;
				end
				elapsed_q <= (now_q > base_time_q) ? now_q - base_time_q : '0;
				delta_q   <= (recv_q > base_bytes_q) ? recv_q - base_bytes_q : '0;
			end
			S_CHECK: begin
				// baseline moves to this report when the rate is updated
				if (DVW'(elapsed_q) >= interval_ext) begin
					base_time_q  <= now_q;
					base_bytes_q <= recv_q;
				end
			end
			// delta times 1000 as 1024 - 16 - 8
			S_MUL1: acc_q <= (AW'(delta_q) << 10) - (AW'(delta_q) << 4);
			S_MUL2: acc_q <= acc_q - (AW'(delta_q) << 3);
			S_INST: begin
				inst_q <= RMAX;
				rem_q  <= inst_rem0;
				dvs_q  <= DVW'(elapsed_q);
				feed_q <= QW'(acc_q[CW-1:0]) << RATE_FRAC_BITS;
				quo_q  <= '0;
				cnt_q  <= CNTW'(QW);
			end
			S_INST_RUN: begin
				if (div_last) begin
					inst_q <= quo_nxt;
				end
			end
			// seven times old plus three times new
			S_SMA: acc_q <= (AW'(smooth_q) << 3) - AW'(smooth_q);
			S_SMB: acc_q <= acc_q + (AW'(inst_q) << 1);
			S_SMC: acc_q <= acc_q + AW'(inst_q);
			S_SM_LD: begin
				rem_q  <= DVW'(acc_q >> RW);
				dvs_q  <= DVW'(SMOOTH_DIVISOR);
				feed_q <= acc_q[QW-1:0];
				quo_q  <= '0;
				cnt_q  <= CNTW'(QW);
			end
			S_ETA_PREP: acc_q <= AW'(expt_q - recv_q);
			S_ETA_LD: begin
				rem_q  <= eta_rem0;
				dvs_q  <= DVW'(smooth_q);
				feed_q <= QW'(eta_num[ETA_STEPS-1:0]) << (QW - ETA_STEPS);
				quo_q  <= '0;
				cnt_q  <= CNTW'(ETA_STEPS);
			end
			S_OUT: begin
				if (out_free) begin
					res_recv_q  <= recv_q;
					res_expt_q  <= expt_q;
					res_ratio_q <= ratio_q;
					res_rate_q  <= smooth_q;
					res_eta_q   <= eta_q;
					res_upd_q   <= upd_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result channel
	assign result.valid          = out_valid_q;
	assign result.received_total = res_recv_q;
	assign result.expected_total = res_expt_q;
	assign result.progress_ratio = res_ratio_q;
	assign result.rate_fixed     = res_rate_q;
	assign result.eta_seconds    = $signed(res_eta_q);
	assign result.rate_updated   = res_upd_q;

	// divider remainder stays below the divisor while it runs
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		div_run |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

	// a running division never has an empty step count
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		div_run |-> (cnt_q != '0))
		else $error("divider running with zero steps left");

	// eta is unknown or non-negative
	a_eta_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eta_q == ETA_UNKNOWN) || !eta_q[ETA_BITS-1])
		else $error("eta holds a negative value other than unknown");

	// a clear drops the baseline before the report is worked on
	a_clear_base: assert property (@(posedge clk) disable iff (!arst_n)
		(report_fire && report.clear_history) |=> !base_valid_q)
		else $error("baseline kept across a clear");

	// ratio never exceeds full scale
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_ratio_q <= RATIO_FULL))
		else $error("progress ratio above full scale");

endmodule

// ----- tb/sv/tb_transfer_rate_eta_estimator.sv -----
`timescale 1ns / 1ps
// tb_transfer_rate_eta_estimator: self-checking bench for the rate and eta estimator
// drives directed and random progress reports, predicts every result and compares
// depends on trate_pkg, the channel interfaces in trate_if.sv and the estimator rtl

module tb_transfer_rate_eta_estimator;
	import trate_pkg::*;

	localparam int COUNT_BITS     = 48;
	localparam int RATE_FRAC_BITS = 8;
	localparam int RATE_BITS      = COUNT_BITS + RATE_FRAC_BITS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 250;
	localparam int HOLD_CYCLES    = 600;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_REPORTS  = 100;
	localparam int PRINT_LIMIT    = 100;

	// index past the last register, the block must ignore it
	localparam cfg_index_t REG_SPARE = REG_SAMPLE_INTERVAL + 8'd1;

	typedef logic [127:0] wide_t;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [RATE_BITS-1:0]  RATE_MAX  = '1;
	localparam wide_t                 RATE_ONE  = wide_t'(1) << RATE_FRAC_BITS;

	typedef struct packed {
		field_t bytes_so_far;
		field_t bytes_expected;
		field_t time_ms;
		logic   clear_history;
	} report_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] received_total;
		logic [COUNT_BITS-1:0] expected_total;
		logic [RATIO_BITS-1:0] progress_ratio;
		logic [RATE_BITS-1:0]  rate_fixed;
		logic [ETA_BITS-1:0]   eta_seconds;
		logic                  rate_updated;
	} progress_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       rep_valid = 1'b0;
	report_t    rep_item  = '0;
	logic       res_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_data_t  cfg_data  = '0;
	logic       hold_arm  = 1'b0;
	int         hold_left = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int idle_cycles    = 0;
	int send_idle_by_phase[4]  = '{0, 86, 0, 17};
	int recv_stall_by_phase[4] = '{0, 0, 86, 17};

	report_t   report_backlog[$];
	progress_t expected_progress[$];

	// predictor copy of the registers and the history
	field_t                    offset_bytes = '0;
	logic [INTERVAL_BITS-1:0]  min_gap_ms   = INTERVAL_RESET;
	logic                      hist_valid   = 1'b0;
	field_t                    hist_time    = '0;
	field_t                    hist_bytes   = '0;
	logic [RATE_BITS-1:0]      avg_rate     = '0;
	logic [ETA_BITS-1:0]       eta_left     = ETA_UNKNOWN;

	trate_report_if report_ch ();
	trate_result_if #(.COUNT_BITS(COUNT_BITS), .RATE_FRAC_BITS(RATE_FRAC_BITS)) result_ch ();
	trate_cfg_if cfg_ch ();

	assign report_ch.valid          = rep_valid;
	assign report_ch.bytes_so_far   = rep_item.bytes_so_far;
	assign report_ch.bytes_expected = rep_item.bytes_expected;
	assign report_ch.time_ms        = rep_item.time_ms;
	assign report_ch.clear_history  = rep_item.clear_history;
	assign result_ch.ready          = res_ready;
	assign cfg_ch.valid             = cfg_valid;
	assign cfg_ch.index             = cfg_index;
	assign cfg_ch.data              = cfg_data;

	transfer_rate_eta_estimator #(
		.COUNT_BITS(COUNT_BITS),
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_ch.sink),
		.result(result_ch.source),
		.cfg(cfg_ch.sink)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturating count sum
	function automatic field_t sat_sum(field_t a, field_t b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	// floor division clamped to cap, divide by zero gives cap
	function automatic wide_t quot_sat(wide_t num, wide_t den, wide_t cap);
		wide_t q;
		if (den == '0)
			return cap;
		q = num / den;
		return (q > cap) ? cap : q;
	endfunction

	function automatic void drop_history();
		hist_valid = 1'b0;
		hist_time  = '0;
		hist_bytes = '0;
		avg_rate   = '0;
		eta_left   = ETA_UNKNOWN;
	endfunction

	// expected result of one report, advances the predictor history
	function automatic progress_t predict_progress(report_t r);
		progress_t p;
		field_t    gap;
		field_t    elapsed;
		field_t    delta;
		wide_t     q;
		if (r.clear_history)
			drop_history();
		p.received_total = sat_sum(offset_bytes, r.bytes_so_far);
		p.expected_total = (r.bytes_expected != '0) ? sat_sum(offset_bytes, r.bytes_expected) : '0;
		p.progress_ratio = '0;
		if (p.expected_total != '0) begin
			q = quot_sat(wide_t'(p.received_total) << RATIO_STEPS, wide_t'(p.expected_total),
				wide_t'(RATIO_FULL));
			p.progress_ratio = q[RATIO_BITS-1:0];
		end
		p.rate_updated = 1'b0;
		if (!hist_valid) begin
			hist_valid = 1'b1;
			hist_time  = r.time_ms;
			hist_bytes = p.received_total;
		end else begin
			gap     = (min_gap_ms == '0) ? field_t'(1) : field_t'(min_gap_ms);
			elapsed = (r.time_ms > hist_time) ? r.time_ms - hist_time : '0;
			if (elapsed >= gap) begin
				delta = (p.received_total > hist_bytes) ? p.received_total - hist_bytes : '0;
				q = quot_sat(wide_t'(delta) * (wide_t'(1000) << RATE_FRAC_BITS), wide_t'(elapsed),
					wide_t'(RATE_MAX));
				// ema only once a nonzero rate exists
				if (avg_rate != '0)
					q = quot_sat(wide_t'(avg_rate) * wide_t'(7) + q * wide_t'(3),
						wide_t'(SMOOTH_DIVISOR), wide_t'(RATE_MAX));
				avg_rate = q[RATE_BITS-1:0];
				if (wide_t'(avg_rate) > RATE_ONE && p.expected_total > p.received_total) begin
					q = quot_sat(wide_t'(p.expected_total - p.received_total) << RATE_FRAC_BITS,
						wide_t'(avg_rate), wide_t'(ETA_MAX));
					eta_left = q[ETA_BITS-1:0];
				end else begin
					eta_left = ETA_UNKNOWN;
				end
				hist_time      = r.time_ms;
				hist_bytes     = p.received_total;
				p.rate_updated = 1'b1;
			end
		end
		p.rate_fixed  = avg_rate;
		p.eta_seconds = eta_left;
		return p;
	endfunction

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_result();
		progress_t want;
		if (expected_progress.size() == 0) begin
			report_error("result with no report waiting for it");
			return;
		end
		want = expected_progress.pop_front();
		if (result_ch.received_total !== want.received_total)
			report_error($sformatf("received_total got %0h want %0h",
				result_ch.received_total, want.received_total));
		if (result_ch.expected_total !== want.expected_total)
			report_error($sformatf("expected_total got %0h want %0h",
				result_ch.expected_total, want.expected_total));
		if (result_ch.progress_ratio !== want.progress_ratio)
			report_error($sformatf("progress_ratio got %0h want %0h",
				result_ch.progress_ratio, want.progress_ratio));
		if (result_ch.rate_fixed !== want.rate_fixed)
			report_error($sformatf("rate_fixed got %0h want %0h",
				result_ch.rate_fixed, want.rate_fixed));
		if (result_ch.eta_seconds !== want.eta_seconds)
			report_error($sformatf("eta_seconds got %0h want %0h",
				result_ch.eta_seconds, want.eta_seconds));
		if (result_ch.rate_updated !== want.rate_updated)
			report_error($sformatf("rate_updated got %0b want %0b",
				result_ch.rate_updated, want.rate_updated));
	endtask

	// report driver: predicts on every transfer, refills from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid <= 1'b0;
		end else begin
			if (rep_valid && report_ch.ready)
				expected_progress.push_back(predict_progress(rep_item));
			if (!rep_valid || report_ch.ready) begin
				if (report_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rep_item  <= report_backlog.pop_front();
					rep_valid <= 1'b1;
				end else begin
					rep_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stalls and the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_ch.valid && res_ready)
				check_result();
			res_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// hold-off counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rep_valid && report_ch.ready) || (result_ch.valid && res_ready)
				|| (cfg_valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("transfer_rate_eta_estimator test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(cfg_index_t idx, cfg_data_t value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RESUME_OFFSET:   offset_bytes = value;
			REG_SAMPLE_INTERVAL: min_gap_ms = value[INTERVAL_BITS-1:0];
			default: ;
		endcase
	endtask

	// wait until every report is taken and every result checked
	task automatic drain();
		while (report_backlog.size() != 0 || rep_valid || expected_progress.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic field_t rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[COUNT_BITS-1:0];
	endfunction

	// random value of random magnitude
	function automatic field_t rand_mag();
		return rand48() >> $urandom_range(COUNT_BITS - 1);
	endfunction

	function automatic void add_report(field_t got, field_t total, field_t stamp, logic clr);
		report_t r;
		r.bytes_so_far   = got;
		r.bytes_expected = total;
		r.time_ms        = stamp;
		r.clear_history  = clr;
		report_backlog.push_back(r);
	endfunction

	function automatic void add_noise();
		add_report(rand_mag(), ($urandom_range(3) == 0) ? '0 : rand48(), rand48(),
			logic'($urandom_range(1)));
	endfunction

	// one transfer: mostly growing counts, time steps around the sample interval
	function automatic int add_transfer();
		int     steps;
		field_t stamp;
		field_t got;
		field_t total;
		field_t span;
		steps = $urandom_range(12, 3);
		stamp = ($urandom_range(3) == 0) ? rand_mag() : field_t'($urandom_range(100000));
		total = ($urandom_range(4) == 0) ? '0 : (rand_mag() | field_t'(1));
		got   = ($urandom_range(3) == 0) ? rand_mag() : '0;
		span  = field_t'(min_gap_ms) + field_t'(1);
		for (int k = 0; k < steps; k++) begin
			if (k != 0) begin
				case ($urandom_range(9))
					0, 1: stamp += field_t'($urandom_range(min_gap_ms));
					8: stamp += rand_mag();
					9: stamp -= field_t'($urandom_range(50, 1));
					default: stamp += span + field_t'($urandom_range(2 * min_gap_ms + 5));
				endcase
				case ($urandom_range(9))
					0: got -= got >> $urandom_range(8, 1);
					1: got += rand_mag();
					default: got += (total >> $urandom_range(6, 1)) + field_t'($urandom_range(5000));
				endcase
			end
			add_report(got, total, stamp,
				(k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(19) == 0));
		end
		return steps;
	endfunction

	function automatic cfg_data_t pick_offset();
		case ($urandom_range(5))
			0, 1: return '0;
			2: return COUNT_MAX;
			3, 4: return cfg_data_t'($urandom_range(100000));
			default: return rand_mag();
		endcase
	endfunction

	// interval in the low bits, upper bits of the data word are don't care
	function automatic cfg_data_t pick_interval();
		cfg_data_t v;
		v = ($urandom_range(1) == 0) ? rand48() : '0;
		case ($urandom_range(3))
			0: v[INTERVAL_BITS-1:0] = 16'd1;
			1: v[INTERVAL_BITS-1:0] = 16'hFFFF;
			2: v[INTERVAL_BITS-1:0] = INTERVAL_RESET;
			default: v[INTERVAL_BITS-1:0] = 16'($urandom_range(2000, 1));
		endcase
		return v;
	endfunction

	initial begin
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default settings: baseline, short gap, update, ema, clamp, bytes down, time back
		write_reg(REG_RESUME_OFFSET, '0);
		write_reg(REG_SAMPLE_INTERVAL, cfg_data_t'(INTERVAL_RESET));
		add_report(48'd0, 48'd0, 48'd0, 1'b0);
		add_report(48'd1000, 48'd10000, 48'd499, 1'b0);
		add_report(48'd5000, 48'd10000, 48'd1000, 1'b0);
		add_report(48'd9000, 48'd10000, 48'd1500, 1'b0);
		add_report(48'd12000, 48'd10000, 48'd2000, 1'b0);
		add_report(48'd11000, 48'd10000, 48'd2600, 1'b0);
		add_report(48'd11500, 48'd10000, 48'd100, 1'b0);
		add_report(48'd0, COUNT_MAX, COUNT_MAX, 1'b1);
		add_report(COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
		drain();

		// one ms interval: rate saturation, eta saturation, rate of exactly one byte/s
		write_reg(REG_SAMPLE_INTERVAL, cfg_data_t'(1));
		add_report(48'd0, COUNT_MAX, 48'd0, 1'b1);
		add_report(COUNT_MAX, COUNT_MAX, 48'd1, 1'b0);
		add_report(48'd0, COUNT_MAX, 48'd1000, 1'b1);
		add_report(48'd1, COUNT_MAX, 48'd1996, 1'b0);
		add_report(48'd2, COUNT_MAX, 48'd2996, 1'b0);
		drain();

		// full offset saturates the sums, zero interval acts as one, spare index ignored
		write_reg(REG_RESUME_OFFSET, COUNT_MAX);
		write_reg(REG_SAMPLE_INTERVAL, '0);
		write_reg(REG_SPARE, rand48());
		add_report(48'd5, 48'd7, 48'd10, 1'b1);
		add_report(COUNT_MAX, 48'd0, 48'd11, 1'b0);
		add_report(48'd100, 48'd0, 48'd11, 1'b0);
		drain();

		// random phases, each with its own settings and idling
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			send_idle_pct  = send_idle_by_phase[ph % 4];
			recv_stall_pct = recv_stall_by_phase[ph % 4];
			write_reg(REG_RESUME_OFFSET, pick_offset());
			write_reg(REG_SAMPLE_INTERVAL, pick_interval());
			if (ph == 4) begin
				hold_arm <= 1'b1;
				@(posedge clk);
				hold_arm <= 1'b0;
			end
			n = 0;
			while (n < PHASE_REPORTS) begin
				if ($urandom_range(9) < 8) begin
					n += add_transfer();
				end else begin
					add_noise();
					n++;
				end
			end
			drain();
		end

		if (error_count == 0)
			$display("transfer_rate_eta_estimator test passed");
		else
			$display("transfer_rate_eta_estimator test failed");
		$finish;
	end

endmodule
